>>> rtl/lexicographic_combination_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lexicographic combination generator
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LEXICOGRAPHIC_COMBINATION_GENERATOR_MACROS_SVH
`define LEXICOGRAPHIC_COMBINATION_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define LCG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcg assertion failed");

// Consequent must hold in the cycle after the antecedent
`define LCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcg assertion failed");

`else

`define LCG_ASSERT_SAME(label, ante, cons)

`define LCG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Types, codes and width helpers shared by the combination generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

  // Default sizes
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned MAX_CHOOSE_DEF  = 16;

  // Fixed field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned LOAD_IDX_W = 6;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SET_SIZE_W = 7;
  localparam int unsigned CHOOSE_W   = 5;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NEXT    = 2'd1,
    FUNC_RESTART = 2'd2
  } lcg_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ELEM      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } lcg_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_SIZE    = 1'b0,
    CFG_CHOOSE_SIZE = 1'b1
  } lcg_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SEARCH,
    ST_FILL
  } lcg_state_e;

  typedef enum logic [1:0] {
    IDX_NOP,
    IDX_RESTART,
    IDX_STEP
  } lcg_idx_op_e;

  // Input beat
  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [ELEM_W-1:0]     load_value;
  } lcg_in_t;

  // Result beat
  typedef struct packed {
    logic [ELEM_W-1:0]   element;
    logic [POS_W-1:0]    position;
    logic                last;
    logic [STATUS_W-1:0] status;
  } lcg_out_t;

  // Sequencer to index unit
  typedef struct packed {
    lcg_idx_op_e op;
  } lcg_idx_cmd_t;

  // Index unit to sequencer
  typedef struct packed {
    logic stuck;  // selected index cannot rise any further
    logic oor;    // selected index lies beyond the table
  } lcg_idx_stat_t;

  // Registered result side information
  typedef struct packed {
    logic                strobe;
    logic [POS_W-1:0]    position;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                zero;
  } lcg_meta_t;

  function automatic int unsigned clog2_min1(input int unsigned x);
    return (x > 1) ? $clog2(x) : 1;
  endfunction

  function automatic int unsigned addr_w(input int unsigned td);
    return clog2_min1(td);
  endfunction

  function automatic int unsigned ptr_w(input int unsigned mc);
    return clog2_min1(mc);
  endfunction

  function automatic int unsigned idx_w(input int unsigned td, input int unsigned mc);
    return clog2_min1((td > mc) ? td : mc);
  endfunction

  function automatic int unsigned n_w(input int unsigned td);
    return $clog2(td + 1);
  endfunction

  function automatic int unsigned m_w(input int unsigned mc);
    return $clog2(mc + 1);
  endfunction

  function automatic int unsigned cmp_w(input int unsigned td, input int unsigned mc);
    return ((idx_w(td, mc) > SET_SIZE_W) ? idx_w(td, mc) : SET_SIZE_W) + 2;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lcg_table.sv
// ----------------------------------------------------------------------------
// lcg_table
// Element table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_table #(
  parameter int unsigned TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned ADDR_W = lcg_pkg::addr_w(TABLE_DEPTH)
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [ADDR_W-1:0]          waddr_i,
  input  wire  [lcg_pkg::ELEM_W-1:0] wdata_i,
  input  wire                        re_i,
  input  wire  [ADDR_W-1:0]          raddr_i,
  output logic [lcg_pkg::ELEM_W-1:0] rdata_o
);
  import lcg_pkg::*;

  logic [ELEM_W-1:0] mem [TABLE_DEPTH];
  logic [ELEM_W-1:0] rdata_q;

  // Write a loaded element
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one element per cycle while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lcg_idx.sv
// ----------------------------------------------------------------------------
// lcg_idx
// Index registers with one shared increment and limit compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_idx #(
  parameter int unsigned TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CHOOSE  = lcg_pkg::MAX_CHOOSE_DEF,
  localparam int unsigned ADDR_W = lcg_pkg::addr_w(TABLE_DEPTH),
  localparam int unsigned PTR_W  = lcg_pkg::ptr_w(MAX_CHOOSE),
  localparam int unsigned N_W    = lcg_pkg::n_w(TABLE_DEPTH),
  localparam int unsigned M_W    = lcg_pkg::m_w(MAX_CHOOSE)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  lcg_pkg::lcg_idx_cmd_t  cmd_i,
  input  wire  [PTR_W-1:0]       ptr_i,
  input  wire  [N_W-1:0]         n_i,
  input  wire  [M_W-1:0]         m_i,
  output lcg_pkg::lcg_idx_stat_t stat_o,
  output logic [ADDR_W-1:0]      rd_addr_o
);
  import lcg_pkg::*;

  localparam int unsigned IDX_W = idx_w(TABLE_DEPTH, MAX_CHOOSE);
  localparam int unsigned CMP_W = cmp_w(TABLE_DEPTH, MAX_CHOOSE);

  logic [IDX_W-1:0] idx_q [MAX_CHOOSE];
  logic [IDX_W-1:0] run_q;
  logic             run_sel_q;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] sum;
  logic [CMP_W-1:0] cur_w;

  // Select the index under the pointer
  assign cur   = idx_q[ptr_i];
  assign cur_w = CMP_W'(cur);

  // Limit compare: index can no longer rise when idx + m >= n + ptr
  assign stat_o.stuck = (cur_w + CMP_W'(m_i)) >= (CMP_W'(n_i) + CMP_W'(ptr_i));
  assign stat_o.oor   = cur_w >= CMP_W'(TABLE_DEPTH);
  assign rd_addr_o    = cur_w[ADDR_W-1:0];

  // Shared incrementer: first step bumps the selected index, later steps
  // continue from the value written last
  assign base = (cmd_i.op == IDX_STEP && run_sel_q) ? run_q : cur;
  assign sum  = base + IDX_W'(1);

  // Update index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_CHOOSE; k++) begin
        idx_q[k] <= IDX_W'(k);
      end
      run_q     <= '0;
      run_sel_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        IDX_RESTART: begin
          for (int k = 0; k < MAX_CHOOSE; k++) begin
            if (CMP_W'(k) < CMP_W'(m_i)) begin
              idx_q[k] <= IDX_W'(k);
            end
          end
          run_sel_q <= 1'b0;
        end
        IDX_STEP: begin
          idx_q[ptr_i] <= sum;
          run_q        <= sum;
          run_sel_q    <= 1'b1;
        end
        default: begin
          run_sel_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcg_seq.sv
// ----------------------------------------------------------------------------
// lcg_seq
// Sequencer: decodes beats, walks the emit, search and fill phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_seq #(
  parameter int unsigned TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CHOOSE  = lcg_pkg::MAX_CHOOSE_DEF,
  localparam int unsigned PTR_W = lcg_pkg::ptr_w(MAX_CHOOSE),
  localparam int unsigned N_W   = lcg_pkg::n_w(TABLE_DEPTH),
  localparam int unsigned M_W   = lcg_pkg::m_w(MAX_CHOOSE)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire  [lcg_pkg::FUNC_W-1:0]   func_i,
  input  wire  [N_W-1:0]               n_i,
  input  wire  [M_W-1:0]               m_i,
  input  lcg_pkg::lcg_idx_stat_t       idx_stat_i,
  output lcg_pkg::lcg_idx_cmd_t        idx_cmd_o,
  output logic [PTR_W-1:0]             ptr_o,
  output logic                         rd_en_o,
  output lcg_pkg::lcg_meta_t           meta_o,
  output logic                         busy_o
);
  import lcg_pkg::*;

  localparam int unsigned CMP_W = cmp_w(TABLE_DEPTH, MAX_CHOOSE);

  lcg_state_e         state_q, state_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic               exh_q, exh_d;
  lcg_meta_t          meta_q, meta_d;
  logic               at_last;
  logic [PTR_W+3:0]   ptr_ext;

  assign at_last = (CMP_W'(ptr_q) + CMP_W'(1)) == CMP_W'(m_i);
  assign ptr_ext = (PTR_W + 4)'(ptr_q);

  // Next state and data
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    exh_d   = exh_q;
    meta_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          unique case (func_i)
            FUNC_NEXT: begin
              if (exh_q) begin
                meta_d = '{strobe: 1'b1, position: '0, last: 1'b1,
                           status: STAT_EXHAUSTED, zero: 1'b1};
              end else if (m_i == '0) begin
                meta_d = '{strobe: 1'b1, position: '0, last: 1'b1,
                           status: STAT_EMPTY, zero: 1'b1};
                exh_d  = 1'b1;
              end else begin
                ptr_d   = '0;
                state_d = ST_EMIT;
              end
            end
            FUNC_RESTART: begin
              exh_d = CMP_W'(n_i) < CMP_W'(m_i);
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        meta_d = '{strobe: 1'b1, position: ptr_ext[POS_W-1:0], last: at_last,
                   status: STAT_ELEM, zero: idx_stat_i.oor};
        if (at_last) begin
          state_d = ST_SEARCH;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      ST_SEARCH: begin
        if (idx_stat_i.stuck) begin
          if (ptr_q == '0) begin
            exh_d   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q - PTR_W'(1);
          end
        end else if (at_last) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d   = ptr_q + PTR_W'(1);
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (at_last) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs to index unit and table
  always_comb begin
    idx_cmd_o.op = IDX_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i && func_i == FUNC_RESTART) begin
          idx_cmd_o.op = IDX_RESTART;
        end
      end
      ST_SEARCH: begin
        if (!idx_stat_i.stuck) begin
          idx_cmd_o.op = IDX_STEP;
        end
      end
      ST_FILL: begin
        idx_cmd_o.op = IDX_STEP;
      end
      default: begin
      end
    endcase
    rd_en_o = (state_q == ST_EMIT);
    busy_o  = (state_q != ST_IDLE);
  end

  assign ptr_o  = ptr_q;
  assign meta_o = meta_q;

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      exh_q   <= 1'b0;
      meta_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      exh_q   <= exh_d;
      meta_q  <= meta_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lexicographic_combination_generator.sv
// ----------------------------------------------------------------------------
// lexicographic_combination_generator
// Enumerates size-m subsets of a loaded element table in lexicographic order.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  input    | start_i high, busy_o low  | in_i  (func, load_index, load_value)
//  result   | result_valid_o, 1 cycle   | res_o (element, position, last, status)
//  config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
//  Load, restart, unused codes and one-beat requests (empty or exhausted)
//  leave busy_o low; a one-beat result shows the cycle after acceptance.
//  A request with m elements keeps busy_o high through m emit steps, up to
//  m search steps and fewer than m fill steps, all through the single index
//  register port and its incrementer; elements leave the registered table port.
//  Reset clears control state and index registers; the table holds no reset
//  and needs no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lexicographic_combination_generator #(
  parameter int unsigned TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CHOOSE  = lcg_pkg::MAX_CHOOSE_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  lcg_pkg::lcg_in_t              in_i,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output lcg_pkg::lcg_out_t             res_o,
  input  wire                           cfg_we_i,
  input  wire  [lcg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [lcg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lcg_pkg::*;

  `include "lexicographic_combination_generator_macros.svh"

  localparam int unsigned ADDR_W = addr_w(TABLE_DEPTH);
  localparam int unsigned PTR_W  = ptr_w(MAX_CHOOSE);
  localparam int unsigned N_W    = n_w(TABLE_DEPTH);
  localparam int unsigned M_W    = m_w(MAX_CHOOSE);
  localparam int unsigned CMP_W  = cmp_w(TABLE_DEPTH, MAX_CHOOSE);

  logic [SET_SIZE_W-1:0] set_size_q;
  logic [CHOOSE_W-1:0]   choose_size_q;
  logic [CMP_W-1:0]      n_wide, m_wide, load_wide;
  logic [N_W-1:0]        n_eff;
  logic [M_W-1:0]        m_eff;
  logic                  accept;
  logic                  tbl_we;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ELEM_W-1:0]     rd_data;
  logic [PTR_W-1:0]      ptr;
  lcg_idx_cmd_t          idx_cmd;
  lcg_idx_stat_t         idx_stat;
  lcg_meta_t             meta;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= '0;
      choose_size_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_SIZE:    set_size_q    <= cfg_wdata_i[SET_SIZE_W-1:0];
        CFG_CHOOSE_SIZE: choose_size_q <= cfg_wdata_i[CHOOSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp n and m to the built sizes
  always_comb begin
    n_wide = CMP_W'(set_size_q);
    if (n_wide > CMP_W'(TABLE_DEPTH)) begin
      n_wide = CMP_W'(TABLE_DEPTH);
    end
    m_wide = CMP_W'(choose_size_q);
    if (m_wide > CMP_W'(MAX_CHOOSE)) begin
      m_wide = CMP_W'(MAX_CHOOSE);
    end
  end

  assign n_eff = n_wide[N_W-1:0];
  assign m_eff = m_wide[M_W-1:0];

  // Accept a beat and decode table loads
  assign accept    = start_i && !busy_o;
  assign load_wide = CMP_W'(in_i.load_index);
  assign tbl_we    = accept && (in_i.func == FUNC_LOAD) && (load_wide < CMP_W'(TABLE_DEPTH));

  lcg_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (load_wide[ADDR_W-1:0]),
    .wdata_i (in_i.load_value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lcg_idx #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHOOSE  (MAX_CHOOSE)
  ) u_idx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (idx_cmd),
    .ptr_i     (ptr),
    .n_i       (n_eff),
    .m_i       (m_eff),
    .stat_o    (idx_stat),
    .rd_addr_o (rd_addr)
  );

  lcg_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHOOSE  (MAX_CHOOSE)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (in_i.func),
    .n_i        (n_eff),
    .m_i        (m_eff),
    .idx_stat_i (idx_stat),
    .idx_cmd_o  (idx_cmd),
    .ptr_o      (ptr),
    .rd_en_o    (rd_en),
    .meta_o     (meta),
    .busy_o     (busy_o)
  );

  // Drive the result beat
  assign result_valid_o = meta.strobe;
  assign res_o.element  = meta.zero ? '0 : rd_data;
  assign res_o.position = meta.position;
  assign res_o.last     = meta.last;
  assign res_o.status   = meta.status;

  // A result only follows an accepted beat or ongoing work
  `LCG_ASSERT_SAME(a_res_has_cause, result_valid_o, $past(busy_o) || $past(start_i))
  // Empty and exhausted results are single beats at position zero
  `LCG_ASSERT_SAME(a_status_single, result_valid_o && (res_o.status != STAT_ELEM),
                   res_o.last && (res_o.position == '0))
  // A request either answers at once or starts the walk
  `LCG_ASSERT_NEXT(a_next_progress, accept && (in_i.func == FUNC_NEXT),
                   result_valid_o || busy_o)

endmodule

`default_nettype wire

>>> tb/lexicographic_combination_generator_tb.sv
// ----------------------------------------------------------------------------
// lexicographic_combination_generator_tb
// Drives load, next and restart beats into the combination generator under
// several set and choose sizes and sender gap rates. A built-in predictor
// computes the expected result beats, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
module lexicographic_combination_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  // DUT signals
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  lcg_in_t               in_i        = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  lcg_out_t              res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Beat queues and bookkeeping
  lcg_in_t  pending_beats[$];
  lcg_out_t expected_elems[$];
  logic     beat_taken = 1'b0;
  int       gap_pct    = 0;
  int       fail_count = 0;
  int       beats_sent = 0;
  int       elems_checked = 0;
  int       settings_run = 0;

  // Predictor state
  logic [ELEM_W-1:0]   elem_tbl[TABLE_DEPTH_DEF];
  logic [5:0]          comb_idx[MAX_CHOOSE_DEF];
  logic                comb_done;
  logic [SET_SIZE_W-1:0] cfg_n;
  logic [CHOOSE_W-1:0]   cfg_m;

  lexicographic_combination_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_i           (in_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Record a failure; print only the first few
  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Append one expected result beat
  task automatic expect_beat(input lcg_out_t r);
    expected_elems = {expected_elems, r};
  endtask

  // Advance the predicted enumeration by one accepted beat
  task automatic predict_combination(input lcg_in_t beat);
    int n_eff, m_eff, i, j;
    lcg_out_t r;
    n_eff = (cfg_n > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cfg_n);
    m_eff = (cfg_m > MAX_CHOOSE_DEF) ? MAX_CHOOSE_DEF : int'(cfg_m);
    r = '0;
    case (beat.func)
      FUNC_LOAD: begin
        elem_tbl[beat.load_index] = beat.load_value;
      end
      FUNC_RESTART: begin
        for (i = 0; i < m_eff; i++) comb_idx[i] = 6'(i);
        comb_done = (n_eff < m_eff);
      end
      FUNC_NEXT: begin
        if (comb_done) begin
          r.last   = 1'b1;
          r.status = STAT_EXHAUSTED;
          expect_beat(r);
        end else if (m_eff == 0) begin
          r.last   = 1'b1;
          r.status = STAT_EMPTY;
          expect_beat(r);
          comb_done = 1'b1;
        end else begin
          // Emit the current combination; indices never leave the table
          for (i = 0; i < m_eff; i++) begin
            r.element  = elem_tbl[comb_idx[i]];
            r.position = 4'(i);
            r.last     = (i == m_eff - 1);
            r.status   = STAT_ELEM;
            expect_beat(r);
          end
          // Find the rightmost index that can still rise, then refill to its right
          i = m_eff - 1;
          while (i >= 0 && int'(comb_idx[i]) >= n_eff - m_eff + i) i--;
          if (i < 0) begin
            comb_done = 1'b1;
          end else begin
            comb_idx[i] = comb_idx[i] + 6'd1;
            for (j = i + 1; j < m_eff; j++) comb_idx[j] = comb_idx[j-1] + 6'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drive beats at the falling edge; hold a beat until it is taken
  always @(negedge clk_i) begin : drive
    logic    go;
    lcg_in_t nxt;
    go  = start_i && !beat_taken;
    nxt = in_i;
    if (!rst_ni) begin
      go = 1'b0;
    end else if (!start_i || beat_taken) begin
      go = 1'b0;
      if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
        go  = 1'b1;
        nxt = pending_beats.pop_front();
      end
    end
    start_i <= go;
    in_i    <= nxt;
  end

  // Check result beats first, then predict from the beat taken at this edge
  always @(posedge clk_i) begin : watch
    lcg_out_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        elems_checked++;
        if (expected_elems.size() == 0) begin
          report_fail($sformatf("unexpected beat elem=%h pos=%0d last=%b status=%0d",
                                res_o.element, res_o.position, res_o.last, res_o.status));
        end else begin
          want = expected_elems.pop_front();
          if (res_o.element !== want.element || res_o.position !== want.position ||
              res_o.last !== want.last || res_o.status !== want.status) begin
            report_fail($sformatf({"elem exp %h got %h, pos exp %0d got %0d, ",
                                   "last exp %b got %b, status exp %0d got %0d"},
                                  want.element, res_o.element, want.position,
                                  res_o.position, want.last, res_o.last,
                                  want.status, res_o.status));
          end
        end
      end
      if (start_i && !busy_o) begin
        beats_sent++;
        predict_combination(in_i);
      end
    end
    beat_taken <= rst_ni && start_i && !busy_o;
  end

  task automatic queue_beat(input logic [FUNC_W-1:0] f, input logic [LOAD_IDX_W-1:0] idx,
                            input logic [ELEM_W-1:0] val);
    lcg_in_t b;
    b.func       = f;
    b.load_index = idx;
    b.load_value = val;
    pending_beats = {pending_beats, b};
  endtask

  // Wait until every beat is taken and every expected result has arrived
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || start_i) @(posedge clk_i);
    while (busy_o || expected_elems.size() != 0) @(posedge clk_i);
    // Let loads and restarts that give no result finish
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input lcg_cfg_e which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= value;
    if (which == CFG_SET_SIZE) cfg_n = value;
    else cfg_m = value[CHOOSE_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_sizes(input int n, input int m);
    wait_quiet();
    write_reg(CFG_SET_SIZE, 7'(n));
    write_reg(CFG_CHOOSE_SIZE, 7'(m));
    settings_run++;
  endtask

  // Stimulus
  initial begin : stimulus
    int ph, k, r, n, m;
    cfg_n     = '0;
    cfg_m     = '0;
    comb_done = 1'b0;
    for (k = 0; k < MAX_CHOOSE_DEF; k++) comb_idx[k] = 6'(k);
    for (k = 0; k < TABLE_DEPTH_DEF; k++) elem_tbl[k] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the whole table so that no read hits an unwritten slot
    for (k = 0; k < TABLE_DEPTH_DEF; k++) begin
      queue_beat(FUNC_LOAD, 6'(k), (k == 0) ? 32'h0 :
                 (k == TABLE_DEPTH_DEF - 1) ? 32'hFFFF_FFFF : $urandom);
    end

    // Full walk of 5 choose 3 with a reload mid-way, then exhaustion
    set_sizes(5, 3);
    queue_beat(FUNC_RESTART, 6'h3F, 32'hFFFF_FFFF);
    for (k = 0; k < 11; k++) begin
      queue_beat(FUNC_NEXT, 6'(k), $urandom);
      if (k == 4) queue_beat(FUNC_LOAD, 6'd3, $urandom);
    end
    queue_beat(FUNC_UNUSED, 6'($urandom), $urandom);

    // Empty combination, then exhausted
    set_sizes(5, 0);
    queue_beat(FUNC_RESTART, 6'd0, 32'd0);
    queue_beat(FUNC_NEXT, 6'd0, 32'd0);
    queue_beat(FUNC_NEXT, 6'd0, 32'd0);

    // Fewer elements than the choose size
    set_sizes(2, 3);
    queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);

    // Oversized registers clamp to the table depth and maximum choose size
    set_sizes(127, 31);
    queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);

    // Next without restart after a size change, then a single full-width set
    set_sizes(16, 16);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);
    queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);

    // Empty set
    set_sizes(0, 1);
    queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
    queue_beat(FUNC_NEXT, 6'($urandom), $urandom);

    // Random phases: mostly restart followed by nexts, with loads and noise
    for (ph = 0; ph < 8; ph++) begin
      r = $urandom_range(99);
      n = (r < 70) ? $urandom_range(12) : $urandom_range(127);
      r = $urandom_range(99);
      m = (r < 75) ? $urandom_range(6) : $urandom_range(31);
      set_sizes(n, m);
      case (ph % 4)
        0: gap_pct = 0;
        1: gap_pct = 50;
        2: gap_pct = 0;
        default: gap_pct = 34;
      endcase
      if ($urandom_range(99) < 85) queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
      for (k = 0; k < 22; k++) begin
        r = $urandom_range(99);
        if (r < 8) queue_beat(FUNC_RESTART, 6'($urandom), $urandom);
        else if (r < 16) queue_beat(FUNC_LOAD, 6'($urandom), $urandom);
        else if (r < 20) queue_beat(FUNC_UNUSED, 6'($urandom), $urandom);
        else queue_beat(FUNC_NEXT, 6'($urandom), $urandom);
      end
    end

    // Drain and settle
    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (expected_elems.size() != 0) begin
      report_fail($sformatf("%0d expected beats never arrived", expected_elems.size()));
    end

    $display("Covered %0d input beats over %0d size settings and %0d result beats.",
             beats_sent, settings_run, elems_checked);
    $display("Failures counted: %0d", fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin : watchdog
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
